// ===== src/vfv_pkg.sv =====
// package for the vortex force vector unit: widths, register codes, shared types
`default_nettype none
package vfv_pkg;
	localparam int FRAC_BITS = 16;
	localparam int E_W = 30;
	localparam int ROOT_STEPS = 31;
	localparam int DIV_STEPS = 33;
	localparam int U_W = FRAC_BITS + 1;
	localparam int F_W = U_W + 32;
	localparam int UNIT_SHIFT = 61 - FRAC_BITS;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_AXIS_X   = 3'd3,
		REG_AXIS_Y   = 3'd4,
		REG_AXIS_Z   = 3'd5,
		REG_MAGNITUDE = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic                     zero;
		logic [2:0]               neg;
		logic [2:0][E_W-1:0]      e;
	} side_t;
endpackage
`default_nettype wire

// ===== src/vortex_force_vector_unit.sv =====
// vortex force vector unit: cross product, normalize, scale, fully pipelined
// throughput: one request per cycle while the output is not stalled; 31-stage square root and 33-stage
// reciprocal divider set the depth, every stage holds one request
// a stalled output freezes the whole pipeline; in_stall follows it
// reset clears valid bits and loads configuration reset values
`default_nettype none
module vortex_force_vector_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] pos_x,
	input  wire logic [31:0] pos_y,
	input  wire logic [31:0] pos_z,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      force_x,
	output logic [31:0]      force_y,
	output logic [31:0]      force_z,
	output logic             degenerate
);
	import vfv_pkg::*;

	logic signed [31:0] center_x_q, center_y_q, center_z_q, magnitude_q;
	logic signed [15:0] axis_x_q, axis_y_q, axis_z_q;
	logic [2:0] widx;
	logic en;

	assign pready = 1'b1;
	assign widx = paddr[4:2];
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			axis_x_q <= '0;
			axis_y_q <= 16'sd16384;
			axis_z_q <= '0;
			magnitude_q <= 32'sd65536;
		end else if (psel && penable && pwrite) begin
			case (widx)
				REG_CENTER_X: center_x_q <= pwdata;
				REG_CENTER_Y: center_y_q <= pwdata;
				REG_CENTER_Z: center_z_q <= pwdata;
				REG_AXIS_X: axis_x_q <= pwdata[15:0];
				REG_AXIS_Y: axis_y_q <= pwdata[15:0];
				REG_AXIS_Z: axis_z_q <= pwdata[15:0];
				REG_MAGNITUDE: magnitude_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_CENTER_X: prdata = center_x_q;
			REG_CENTER_Y: prdata = center_y_q;
			REG_CENTER_Z: prdata = center_z_q;
			REG_AXIS_X: prdata = 32'(axis_x_q);
			REG_AXIS_Y: prdata = 32'(axis_y_q);
			REG_AXIS_Z: prdata = 32'(axis_z_q);
			REG_MAGNITUDE: prdata = magnitude_q;
			default: prdata = '0;
		endcase
	end

	// stage 1: difference
	logic v_s1;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	// stage 2: products
	logic v_s2;
	logic signed [48:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;
	// stage 3: cross product magnitudes
	logic v_s3;
	logic [2:0] neg_s3;
	logic [48:0] ea_s3, eb_s3, ec_s3;
	// stage 4: leading one position
	logic v_s4;
	logic [2:0] neg_s4;
	logic [48:0] ea_s4, eb_s4, ec_s4;
	logic [5:0] msb_s4;
	logic zero_s4;
	// stage 5: normalized
	logic v_s5;
	side_t side_s5;
	// stage 6: squares
	logic v_s6;
	side_t side_s6;
	logic [59:0] sqa_s6, sqb_s6, sqc_s6;

	logic signed [49:0] c0, c1, c2;
	logic [48:0] mx;
	logic [5:0] msb;
	logic [48:0] ma, mb, mc;

	always_comb begin
		c0 = 50'(p0_s2) - 50'(p1_s2);
		c1 = 50'(p2_s2) - 50'(p3_s2);
		c2 = 50'(p4_s2) - 50'(p5_s2);
	end

	always_comb begin
		mx = ea_s3;
		if (eb_s3 > mx) mx = eb_s3;
		if (ec_s3 > mx) mx = ec_s3;
		msb = '0;
		for (int i = 0; i < 49; i++) begin
			if (mx[i]) msb = 6'(i);
		end
	end

	always_comb begin
		if (msb_s4 >= 6'd29) begin
			ma = ea_s4 >> (msb_s4 - 6'd29);
			mb = eb_s4 >> (msb_s4 - 6'd29);
			mc = ec_s4 >> (msb_s4 - 6'd29);
		end else begin
			ma = ea_s4 << (6'd29 - msb_s4);
			mb = eb_s4 << (6'd29 - msb_s4);
			mc = ec_s4 << (6'd29 - msb_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= 33'(center_x_q) - 33'($signed(pos_x));
			dy_s1 <= 33'(center_y_q) - 33'($signed(pos_y));
			dz_s1 <= 33'(center_z_q) - 33'($signed(pos_z));
			p0_s2 <= 49'(dy_s1) * 49'(axis_z_q);
			p1_s2 <= 49'(dz_s1) * 49'(axis_y_q);
			p2_s2 <= 49'(dz_s1) * 49'(axis_x_q);
			p3_s2 <= 49'(dx_s1) * 49'(axis_z_q);
			p4_s2 <= 49'(dx_s1) * 49'(axis_y_q);
			p5_s2 <= 49'(dy_s1) * 49'(axis_x_q);
			neg_s3 <= {c2[49], c1[49], c0[49]};
			ea_s3 <= c0[49] ? 49'(-c0) : c0[48:0];
			eb_s3 <= c1[49] ? 49'(-c1) : c1[48:0];
			ec_s3 <= c2[49] ? 49'(-c2) : c2[48:0];
			neg_s4 <= neg_s3;
			ea_s4 <= ea_s3;
			eb_s4 <= eb_s3;
			ec_s4 <= ec_s3;
			msb_s4 <= msb;
			zero_s4 <= (mx == '0);
			side_s5.zero <= zero_s4;
			side_s5.neg <= neg_s4;
			side_s5.e[0] <= ma[E_W-1:0];
			side_s5.e[1] <= mb[E_W-1:0];
			side_s5.e[2] <= mc[E_W-1:0];
			side_s6 <= side_s5;
			sqa_s6 <= 60'(side_s5.e[0]) * 60'(side_s5.e[0]);
			sqb_s6 <= 60'(side_s5.e[1]) * 60'(side_s5.e[1]);
			sqc_s6 <= 60'(side_s5.e[2]) * 60'(side_s5.e[2]);
		end
	end

	// square root, one result bit per stage
	logic        rt_v_s   [0:ROOT_STEPS];
	side_t       rt_side_s[0:ROOT_STEPS];
	logic [61:0] rt_src_s [0:ROOT_STEPS];
	logic [32:0] rt_rem_s [0:ROOT_STEPS];
	logic [30:0] rt_res_s [0:ROOT_STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s[0] <= 1'b0;
		end else if (en) begin
			rt_v_s[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_side_s[0] <= side_s6;
			rt_src_s[0] <= 62'(sqa_s6) + 62'(sqb_s6) + 62'(sqc_s6);
			rt_rem_s[0] <= '0;
			rt_res_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < ROOT_STEPS; g++) begin : g_root
		logic [32:0] nrem, trial;
		assign nrem = {rt_rem_s[g][30:0], rt_src_s[g][61:60]};
		assign trial = {rt_res_s[g], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[g+1] <= 1'b0;
			end else if (en) begin
				rt_v_s[g+1] <= rt_v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rt_side_s[g+1] <= rt_side_s[g];
				rt_src_s[g+1] <= {rt_src_s[g][59:0], 2'b00};
				if (nrem >= trial) begin
					rt_rem_s[g+1] <= nrem - trial;
					rt_res_s[g+1] <= {rt_res_s[g][29:0], 1'b1};
				end else begin
					rt_rem_s[g+1] <= nrem;
					rt_res_s[g+1] <= {rt_res_s[g][29:0], 1'b0};
				end
			end
		end
	end

	// reciprocal 2^61 / root, one quotient bit per stage
	logic        dv_v_s   [0:DIV_STEPS];
	side_t       dv_side_s[0:DIV_STEPS];
	logic [30:0] dv_den_s [0:DIV_STEPS];
	logic [31:0] dv_rem_s [0:DIV_STEPS];
	logic [32:0] dv_quo_s [0:DIV_STEPS];

	always_comb begin
		dv_v_s[0] = rt_v_s[ROOT_STEPS];
		dv_side_s[0] = rt_side_s[ROOT_STEPS];
		dv_den_s[0] = rt_res_s[ROOT_STEPS];
		dv_rem_s[0] = 32'h1000_0000;
		dv_quo_s[0] = '0;
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		logic [31:0] t;
		assign t = {dv_rem_s[g][30:0], 1'b0};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[g+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[g+1] <= dv_v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				dv_side_s[g+1] <= dv_side_s[g];
				dv_den_s[g+1] <= dv_den_s[g];
				if (t >= {1'b0, dv_den_s[g]}) begin
					dv_rem_s[g+1] <= t - {1'b0, dv_den_s[g]};
					dv_quo_s[g+1] <= {dv_quo_s[g][31:0], 1'b1};
				end else begin
					dv_rem_s[g+1] <= t;
					dv_quo_s[g+1] <= {dv_quo_s[g][31:0], 1'b0};
				end
			end
		end
	end

	// unit vector and scaling, three lanes
	logic v_s7, v_s8, v_s9, v_s10;
	side_t side_s7, side_s8, side_s9;
	logic [2:0][46:0] pph_s7;
	logic [2:0][45:0] ppl_s7;
	logic [2:0][U_W-1:0] u_s8;
	logic [2:0][F_W-1:0] f_s9;
	logic [31:0] fo_s10 [0:2];
	logic zero_s10;
	logic [31:0] mmag;
	logic [32:0] rq;
	logic [62:0] full [0:2];
	logic [F_W-FRAC_BITS-1:0] fs [0:2];
	logic ng [0:2];
	logic [31:0] fo [0:2];

	assign rq = dv_quo_s[DIV_STEPS];
	assign mmag = magnitude_q[31] ? 32'(-magnitude_q) : magnitude_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			full[k] = {pph_s7[k], 16'h0} + 63'(ppl_s7[k]);
			fs[k] = f_s9[k][F_W-1:FRAC_BITS];
			ng[k] = side_s9.neg[k] ^ magnitude_q[31];
			if (ng[k]) begin
				fo[k] = (fs[k] > (F_W-FRAC_BITS)'(33'h0_8000_0000)) ? 32'h8000_0000
					: 32'(-fs[k]);
			end else begin
				fo[k] = (fs[k] > (F_W-FRAC_BITS)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
					: fs[k][31:0];
			end
			if (side_s9.zero) fo[k] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s7 <= dv_v_s[DIV_STEPS];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= dv_side_s[DIV_STEPS];
			side_s8 <= side_s7;
			side_s9 <= side_s8;
			zero_s10 <= side_s9.zero;
			for (int k = 0; k < 3; k++) begin
				pph_s7[k] <= 47'(dv_side_s[DIV_STEPS].e[k]) * 47'(rq[32:16]);
				ppl_s7[k] <= 46'(dv_side_s[DIV_STEPS].e[k]) * 46'(rq[15:0]);
				u_s8[k] <= U_W'(full[k] >> UNIT_SHIFT);
				f_s9[k] <= F_W'(u_s8[k]) * F_W'(mmag);
				fo_s10[k] <= fo[k];
			end
		end
	end

	assign out_valid = v_s10;
	assign force_x = fo_s10[0];
	assign force_y = fo_s10[1];
	assign force_z = fo_s10[2];
	assign degenerate = zero_s10;
endmodule
`default_nettype wire
